// ----- sv/aubc_pkg.sv -----
// ----------------------------------------------------------------------------
// aubc_pkg
// Shared widths, types and control structs of the axis step and bound chooser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aubc_pkg;

  localparam int DATA_WIDTH = 32;              // significant bits of the samples
  localparam int IN_W       = 32;              // input field width
  localparam int SW         = DATA_WIDTH + 1;  // widened values and span
  localparam int NW         = DATA_WIDTH + 8;  // scaled numerators, signed
  localparam int DENW       = SW + 1;          // step in sample units / 10
  localparam int CNTW       = $clog2(NW + 1);
  localparam int EXPW       = 4;

  localparam int MANT_W = 3;
  localparam int EXP_W  = 5;
  localparam int QIDX_W = 37;
  localparam int TICK_W = 35;

  localparam logic [MANT_W-1:0] MANT_1 = 3'd1;
  localparam logic [MANT_W-1:0] MANT_2 = 3'd2;
  localparam logic [MANT_W-1:0] MANT_5 = 3'd5;

  typedef struct packed {
    logic load;
    logic search;
    logic choose;
    logic div_step;
    logic finish;
  } aubc_cmd_t;

  typedef struct packed {
    logic err;
    logic search_done;
    logic div_done;
  } aubc_sts_t;

endpackage

`default_nettype wire

// ----- sv/aubc_if.sv -----
// ----------------------------------------------------------------------------
// aubc_in_if / aubc_out_if
// Valid/ready channels carrying the bounds and the axis result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aubc_in_if import aubc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] low_value;
  logic signed [IN_W-1:0] high_value;
  modport source (output valid, low_value, high_value, input ready);
  modport sink   (input valid, low_value, high_value, output ready);
endinterface

interface aubc_out_if import aubc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [MANT_W-1:0] step_mantissa;
  logic signed [EXP_W-1:0]  step_exponent;
  logic signed [QIDX_W-1:0] low_quarter_index;
  logic signed [QIDX_W-1:0] high_quarter_index;
  logic signed [TICK_W-1:0] first_tick;
  logic signed [TICK_W-1:0] last_tick;
  logic                     range_error;
  modport source (output valid, step_mantissa, step_exponent, low_quarter_index,
                  high_quarter_index, first_tick, last_tick, range_error,
                  input ready);
  modport sink   (input valid, step_mantissa, step_exponent, low_quarter_index,
                  high_quarter_index, first_tick, last_tick, range_error,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/aubc_ctrl.sv -----
// ----------------------------------------------------------------------------
// aubc_ctrl
// Sequencer: accept, decade search, step choice, division, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aubc_ctrl import aubc_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire        out_ready,
  input  aubc_sts_t  sts,
  output aubc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_CHOOSE = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // an inverted range skips all arithmetic
        if (sts.err || sts.search_done) begin
          state_nxt = sts.err ? S_DONE : S_CHOOSE;
        end else begin
          cmd.search = 1'b1;
        end
      end
      S_CHOOSE: begin
        cmd.choose = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/aubc_dp.sv -----
// ----------------------------------------------------------------------------
// aubc_dp
// Widening, decade search, step choice, two bit-serial dividers, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aubc_dp import aubc_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  input  aubc_cmd_t                cmd,
  output aubc_sts_t                sts,
  input  wire signed [IN_W-1:0]    in_low,
  input  wire signed [IN_W-1:0]    in_high,
  output logic       [MANT_W-1:0]  o_mant,
  output logic signed [EXP_W-1:0]  o_exp,
  output logic signed [QIDX_W-1:0] o_lq,
  output logic signed [QIDX_W-1:0] o_hq,
  output logic signed [TICK_W-1:0] o_first,
  output logic signed [TICK_W-1:0] o_last,
  output logic                     o_err
);

  logic signed [SW-1:0] lo_r, hi_r;
  logic        [SW-1:0] span_r, p_r, pp_r;
  logic     [EXPW-1:0]  exp_r;
  logic                 err_r;
  logic       [MANT_W-1:0] m_r;
  logic signed [EXP_W-1:0] e_r;
  logic     [DENW-1:0]  den_r;
  logic     [CNTW-1:0]  cnt_r;
  logic     [NW-1:0]    q_r   [2];
  logic     [DENW-1:0]  rem_r [2];
  logic                 neg_r [2];

  // widening of equal bounds
  logic signed [SW-1:0] lo_x, hi_x, lo_w, hi_w;
  always_comb begin
    lo_x = {in_low[DATA_WIDTH-1], in_low[DATA_WIDTH-1:0]};
    hi_x = {in_high[DATA_WIDTH-1], in_high[DATA_WIDTH-1:0]};
    lo_w = lo_x;
    hi_w = hi_x;
    if (hi_x == lo_x) begin
      if (hi_x > 0)       lo_w = '0;
      else if (hi_x == 0) hi_w = SW'(1);
      else                hi_w = '0;
    end
  end

  logic [SW+3:0] p10, s10, p12, s2, p5, sp;
  assign p10 = {1'b0, p_r, 3'b000} + {3'b000, p_r, 1'b0};
  assign s10 = {1'b0, span_r, 3'b000} + {3'b000, span_r, 1'b0};
  assign p12 = {1'b0, p_r, 3'b000} + {2'b00, p_r, 2'b00};
  assign s2  = {3'b000, span_r, 1'b0};
  assign p5  = {2'b00, p_r, 2'b00} + {4'b0000, p_r};
  assign sp  = {4'b0000, span_r};

  assign sts.err         = err_r;
  assign sts.search_done = (p10 > sp);
  assign sts.div_done    = (cnt_r == CNTW'(NW - 1));

  // step choice from the leading ratio of the span
  logic [MANT_W-1:0]  m_c;
  logic               big_c;
  logic [DENW-1:0]    den_c;
  logic               x40_c;
  always_comb begin
    if (s10 <= p12)      begin m_c = MANT_2; big_c = 1'b0; end
    else if (s2 <= p5)   begin m_c = MANT_5; big_c = 1'b0; end
    else if (sp <= p5)   begin m_c = MANT_1; big_c = 1'b1; end
    else                 begin m_c = MANT_2; big_c = 1'b1; end
    x40_c = !big_c && (exp_r == '0);
    if (big_c)
      den_c = (m_c == MANT_2) ? {p_r, 1'b0} : {1'b0, p_r};
    else if (x40_c)
      den_c = DENW'(m_c);
    else if (m_c == MANT_5)
      den_c = DENW'({pp_r, 2'b00}) + DENW'(pp_r);
    else
      den_c = {pp_r, 1'b0};
  end

  function automatic logic signed [NW-1:0] scale(input logic signed [SW-1:0] v,
                                                 input logic x40);
    logic signed [NW-1:0] ve;
    ve = NW'(v);
    return x40 ? ((ve <<< 5) + (ve <<< 3)) : (ve <<< 2);
  endfunction

  logic signed [NW-1:0] num_c [2];
  assign num_c[0] = scale(lo_r, x40_c);
  assign num_c[1] = scale(hi_r, x40_c);

  // restoring division steps, one quotient bit per lane each cycle
  logic [DENW:0] trial [2];
  always_comb begin
    for (int i = 0; i < 2; i++)
      trial[i] = {rem_r[i], q_r[i][NW-1]} - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r   <= lo_w;
      hi_r   <= hi_w;
      err_r  <= (hi_x < lo_x);
      span_r <= SW'(hi_w - lo_w);
      p_r    <= SW'(1);
      pp_r   <= '0;
      exp_r  <= '0;
    end
    if (cmd.search) begin
      pp_r  <= p_r;
      p_r   <= SW'(p10);
      exp_r <= exp_r + 1'b1;
    end
    if (cmd.choose) begin
      m_r   <= m_c;
      e_r   <= big_c ? EXP_W'(exp_r) : EXP_W'(exp_r) - EXP_W'(1);
      den_r <= den_c;
      cnt_r <= '0;
      for (int i = 0; i < 2; i++) begin
        neg_r[i] <= num_c[i][NW-1];
        q_r[i]   <= num_c[i][NW-1] ? NW'(-num_c[i]) : NW'(num_c[i]);
        rem_r[i] <= '0;
      end
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      for (int i = 0; i < 2; i++) begin
        if (!trial[i][DENW]) begin
          rem_r[i] <= trial[i][DENW-1:0];
          q_r[i]   <= {q_r[i][NW-2:0], 1'b1};
        end else begin
          rem_r[i] <= {rem_r[i][DENW-2:0], q_r[i][NW-1]};
          q_r[i]   <= {q_r[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  // floor for the low bound, ceiling for the high bound
  logic signed [NW:0] qs [2];
  logic signed [NW:0] lq_c, hq_c;
  logic signed [NW:0] fst_c;
  always_comb begin
    for (int i = 0; i < 2; i++)
      qs[i] = {1'b0, q_r[i]};
    if (neg_r[0]) lq_c = (rem_r[0] != '0) ? -qs[0] - (NW+1)'(1) : -qs[0];
    else          lq_c = qs[0];
    if (neg_r[1]) hq_c = -qs[1];
    else          hq_c = (rem_r[1] != '0) ? qs[1] + (NW+1)'(1) : qs[1];
    fst_c = (lq_c + (NW+1)'(3)) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_err <= 1'b0;
    end else if (cmd.finish) begin
      o_err <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (err_r) begin
        o_mant  <= '0;
        o_exp   <= '0;
        o_lq    <= '0;
        o_hq    <= '0;
        o_first <= '0;
        o_last  <= '0;
      end else begin
        o_mant  <= m_r;
        o_exp   <= e_r;
        o_lq    <= lq_c[QIDX_W-1:0];
        o_hq    <= hq_c[QIDX_W-1:0];
        o_first <= fst_c[TICK_W-1:0];
        o_last  <= TICK_W'(hq_c >>> 2);
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/axis_unit_and_bound_chooser.sv -----
// ----------------------------------------------------------------------------
// axis_unit_and_bound_chooser
// Picks a 1-2-5 axis step for a data range and snaps the bounds to it.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  in_chan  | in  | low_value, high_value
//  out_chan | out | step_mantissa, step_exponent, low/high_quarter_index,
//           |     | first_tick, last_tick, range_error
//
//  One transaction at a time: an accept state, the decade search, a
//  step-choice state, the two bit-serial dividers, and a hand-off to the
//  output register.
//  An inverted range skips the arithmetic.
//  A waiting result sits in the output register while the next transaction
//  is accepted and worked on. Synchronous reset clears control and error only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module axis_unit_and_bound_chooser import aubc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  aubc_in_if.sink     in_chan,
  aubc_out_if.source  out_chan
);

  aubc_cmd_t cmd;
  aubc_sts_t sts;

  aubc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  aubc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_low  (in_chan.low_value),
    .in_high (in_chan.high_value),
    .o_mant  (out_chan.step_mantissa),
    .o_exp   (out_chan.step_exponent),
    .o_lq    (out_chan.low_quarter_index),
    .o_hq    (out_chan.high_quarter_index),
    .o_first (out_chan.first_tick),
    .o_last  (out_chan.last_tick),
    .o_err   (out_chan.range_error)
  );

endmodule

`default_nettype wire

// ----- sv/aubc_chk.sv -----
// ----------------------------------------------------------------------------
// aubc_chk
// Port-level checks of the axis chooser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aubc_chk import aubc_pkg::*; (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire [MANT_W-1:0]        mant,
  input wire [QIDX_W-1:0]        lq,
  input wire [QIDX_W-1:0]        hq,
  input wire                     err
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mant) && $stable(lq))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err |-> mant == '0 && lq == '0 && hq == '0)
    else $error("error result carries data");

  a_mant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !err |-> mant == MANT_1 || mant == MANT_2 || mant == MANT_5)
    else $error("bad mantissa");

  // in_ready drops once a transaction is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");

endmodule

bind axis_unit_and_bound_chooser aubc_chk u_aubc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .mant      (out_chan.step_mantissa),
  .lq        (out_chan.low_quarter_index),
  .hq        (out_chan.high_quarter_index),
  .err       (out_chan.range_error)
);

`default_nettype wire
